/* hdl/pcadj_pkg.sv */
// shared constants, register index codes and luma weight helper for the pixel color adjust
package pcadj_pkg;

   localparam int FRAC_BITS_DEFAULT = 12;

   localparam int CHAN_W     = 13;
   localparam int OUT_W      = 16;
   localparam int MID_W      = 24;
   localparam int SAT_W      = 14;
   localparam int BRIGHT_W   = 14;
   localparam int CONTRAST_W = 20;
   localparam int BLACK_W    = 10;
   localparam int GAIN_W     = 32;
   localparam int GAIN_SPLIT = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // cycles from the accepting edge of a pixel to the edge that ends its result transfer
   localparam int LATENCY = 10;

   // luma weights in ten-thousandths
   localparam int unsigned LUMA_RED_E4   = 2126;
   localparam int unsigned LUMA_GREEN_E4 = 7152;
   localparam int unsigned LUMA_BLUE_E4  = 722;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAT_SCALE        = 3'd0,
      CSR_BRIGHTNESS_SHIFT = 3'd1,
      CSR_CONTRAST_FACTOR  = 3'd2,
      CSR_BLACK_LEVEL      = 3'd3,
      CSR_EXPOSURE_GAIN    = 3'd4
   } csr_index_type;

   function automatic int unsigned luma_weight(input int unsigned weight_e4,
                                               input int unsigned frac_bits);
      return ((weight_e4 << frac_bits) + 32'd5000) / 32'd10000;
   endfunction

endpackage

/* hdl/pixel_color_adjust_pipeline_top.sv */
// pixel color adjust: saturation, brightness/contrast and exposure on one rgba pixel per cycle
// throughput: one pixel per clock, busy stays low, ten register stages set the latency
// reset: synchronous active-high reset clears the valid chain and loads the default registers
// results cannot be held off by the receiver, every strobe is one transfer
module pixel_color_adjust_pipeline_top #(
   parameter int FRAC_BITS = pcadj_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pcadj_pkg::CHAN_W-1:0]         req_red_in,
   input  logic [pcadj_pkg::CHAN_W-1:0]         req_green_in,
   input  logic [pcadj_pkg::CHAN_W-1:0]         req_blue_in,
   input  logic [pcadj_pkg::CHAN_W-1:0]         req_alpha_in,
   output logic                                 rsp_strobe,
   output logic signed [pcadj_pkg::OUT_W-1:0]   rsp_red_out,
   output logic signed [pcadj_pkg::OUT_W-1:0]   rsp_green_out,
   output logic signed [pcadj_pkg::OUT_W-1:0]   rsp_blue_out,
   output logic [pcadj_pkg::CHAN_W-1:0]         rsp_alpha_out,
   input  logic                                 csr_write_enable,
   input  pcadj_pkg::csr_index_type             csr_index,
   input  logic [pcadj_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import pcadj_pkg::*;

   localparam int ONE  = 1 << FRAC_BITS;
   localparam int HALF = ONE / 2;

   localparam int unsigned WEIGHTS [3] = '{
      luma_weight(LUMA_RED_E4, FRAC_BITS),
      luma_weight(LUMA_GREEN_E4, FRAC_BITS),
      luma_weight(LUMA_BLUE_E4, FRAC_BITS)
   };

   localparam int PROD_W = CHAN_W + FRAC_BITS;
   localparam int SUM_W  = PROD_W + 2;
   localparam int LUMA_W = SUM_W - FRAC_BITS;
   localparam int K_W    = (FRAC_BITS + 2 > SAT_W + 2) ? FRAC_BITS + 2 : SAT_W + 2;
   localparam int S1_W   = LUMA_W + 1 + K_W + 2;
   localparam int E_W    = MID_W + 1;
   localparam int P2_W   = E_W + CONTRAST_W + 1;
   localparam int R2_W   = P2_W + 2;
   localparam int D_W    = MID_W + 1;
   localparam int GLO_W  = GAIN_SPLIT;
   localparam int GHI_W  = GAIN_W - GAIN_SPLIT;
   localparam int PL_W   = D_W + GLO_W + 1;
   localparam int PH_W   = D_W + GHI_W + 1;
   localparam int FULL_W = D_W + GAIN_W + 2;

   // configuration registers
   logic [SAT_W-1:0]             sat_scale_ff;
   logic signed [BRIGHT_W-1:0]   brightness_shift_ff;
   logic [CONTRAST_W-1:0]        contrast_factor_ff;
   logic signed [BLACK_W-1:0]    black_level_ff;
   logic [GAIN_W-1:0]            exposure_gain_ff;

   // valid chain and alpha chain
   logic [LATENCY-1:0]           valid_ff;
   logic                         accept_in;
   logic [CHAN_W-1:0]            alpha_ff [LATENCY];

   // per-lane pipeline registers
   logic [CHAN_W-1:0]            s1_chan_ff [3];
   logic [CHAN_W-1:0]            s2_chan_ff [3];
   logic [CHAN_W-1:0]            s3_chan_ff [3];
   logic [PROD_W-1:0]            s2_prod_ff [3];
   logic [LUMA_W-1:0]            s3_luma_ff;
   logic [LUMA_W-1:0]            s3_luma_in;
   logic [SUM_W-1:0]             luma_sum;
   logic signed [K_W-1:0]        sat_k;
   logic signed [S1_W-1:0]       s4_mix_ff  [3];
   logic signed [S1_W-1:0]       s4_chan_ff [3];
   logic signed [S1_W-1:0]       s5_sum     [3];
   logic signed [S1_W-1:0]       s5_rnd     [3];
   logic signed [MID_W-1:0]      s5_c1_ff   [3];
   logic signed [MID_W-1:0]      s5_c1_in   [3];
   logic signed [E_W-1:0]        s6_cent    [3];
   logic signed [P2_W-1:0]       s6_prod_ff [3];
   logic signed [R2_W-1:0]       s7_rnd     [3];
   logic signed [R2_W-1:0]       s7_sum     [3];
   logic signed [MID_W-1:0]      s7_c2_ff   [3];
   logic signed [MID_W-1:0]      s7_c2_in   [3];
   logic signed [D_W-1:0]        s8_diff    [3];
   logic signed [PL_W-1:0]       s8_lo_ff   [3];
   logic signed [PH_W-1:0]       s8_hi_ff   [3];
   logic signed [FULL_W-1:0]     s9_full_ff [3];
   logic signed [FULL_W-1:0]     s10_sum    [3];
   logic signed [FULL_W-1:0]     s10_rnd    [3];
   logic signed [OUT_W-1:0]      out_ff     [3];
   logic signed [OUT_W-1:0]      out_in     [3];

   assign busy      = 1'b0;
   assign accept_in = start && !busy;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sat_scale_ff        <= SAT_W'(ONE);
         brightness_shift_ff <= '0;
         contrast_factor_ff  <= CONTRAST_W'(ONE);
         black_level_ff      <= '0;
         exposure_gain_ff    <= GAIN_W'(ONE);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SAT_SCALE: begin
               sat_scale_ff <= csr_write_data[SAT_W-1:0];
            end
            CSR_BRIGHTNESS_SHIFT: begin
               brightness_shift_ff <= signed'(csr_write_data[BRIGHT_W-1:0]);
            end
            CSR_CONTRAST_FACTOR: begin
               contrast_factor_ff <= csr_write_data[CONTRAST_W-1:0];
            end
            CSR_BLACK_LEVEL: begin
               black_level_ff <= signed'(csr_write_data[BLACK_W-1:0]);
            end
            CSR_EXPOSURE_GAIN: begin
               exposure_gain_ff <= csr_write_data[GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LATENCY-2:0], accept_in};
      end
   end

   always_ff @(posedge clock) begin
      alpha_ff[0] <= req_alpha_in;
      for (int i = 1; i < LATENCY; i++) begin
         alpha_ff[i] <= alpha_ff[i-1];
      end
   end

   // combinational parts of each stage
   always_comb begin
      luma_sum = SUM_W'(s2_prod_ff[0]) + SUM_W'(s2_prod_ff[1]) + SUM_W'(s2_prod_ff[2])
               + SUM_W'(HALF);
      s3_luma_in = LUMA_W'(luma_sum >> FRAC_BITS);
      sat_k = signed'(K_W'(ONE)) - signed'(K_W'(sat_scale_ff));
      for (int l = 0; l < 3; l++) begin
         // saturation mix, round, limit to mid range
         s5_sum[l] = s4_mix_ff[l] + s4_chan_ff[l] + S1_W'(HALF);
         s5_rnd[l] = s5_sum[l] >>> FRAC_BITS;
         if (&s5_rnd[l][S1_W-1:MID_W-1] || ~|s5_rnd[l][S1_W-1:MID_W-1]) begin
            s5_c1_in[l] = s5_rnd[l][MID_W-1:0];
         end else begin
            s5_c1_in[l] = {s5_rnd[l][S1_W-1], {(MID_W-1){~s5_rnd[l][S1_W-1]}}};
         end
         s6_cent[l] = E_W'(s5_c1_ff[l]) - E_W'(HALF);
         // contrast round, brightness shift, limit to mid range
         s7_rnd[l] = (R2_W'(s6_prod_ff[l]) + R2_W'(HALF)) >>> FRAC_BITS;
         s7_sum[l] = s7_rnd[l] + R2_W'(brightness_shift_ff) + R2_W'(HALF);
         if (&s7_sum[l][R2_W-1:MID_W-1] || ~|s7_sum[l][R2_W-1:MID_W-1]) begin
            s7_c2_in[l] = s7_sum[l][MID_W-1:0];
         end else begin
            s7_c2_in[l] = {s7_sum[l][R2_W-1], {(MID_W-1){~s7_sum[l][R2_W-1]}}};
         end
         s8_diff[l] = D_W'(s7_c2_ff[l]) - D_W'(black_level_ff);
         // exposure round, limit to output range
         s10_sum[l] = s9_full_ff[l] + FULL_W'(HALF);
         s10_rnd[l] = s10_sum[l] >>> FRAC_BITS;
         if (&s10_rnd[l][FULL_W-1:OUT_W-1] || ~|s10_rnd[l][FULL_W-1:OUT_W-1]) begin
            out_in[l] = s10_rnd[l][OUT_W-1:0];
         end else begin
            out_in[l] = {s10_rnd[l][FULL_W-1], {(OUT_W-1){~s10_rnd[l][FULL_W-1]}}};
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s1_chan_ff[0] <= req_red_in;
      s1_chan_ff[1] <= req_green_in;
      s1_chan_ff[2] <= req_blue_in;
      s3_luma_ff    <= s3_luma_in;
      for (int l = 0; l < 3; l++) begin
         s2_chan_ff[l] <= s1_chan_ff[l];
         s2_prod_ff[l] <= PROD_W'(s1_chan_ff[l]) * PROD_W'(WEIGHTS[l]);
         s3_chan_ff[l] <= s2_chan_ff[l];
         s4_mix_ff[l]  <= S1_W'(signed'({1'b0, s3_luma_ff})) * S1_W'(sat_k);
         s4_chan_ff[l] <= S1_W'(signed'({1'b0, s3_chan_ff[l]}))
                        * S1_W'(signed'({1'b0, sat_scale_ff}));
         s5_c1_ff[l]   <= s5_c1_in[l];
         s6_prod_ff[l] <= P2_W'(s6_cent[l]) * P2_W'(signed'({1'b0, contrast_factor_ff}));
         s7_c2_ff[l]   <= s7_c2_in[l];
         s8_lo_ff[l]   <= PL_W'(s8_diff[l])
                        * PL_W'(signed'({1'b0, exposure_gain_ff[GLO_W-1:0]}));
         s8_hi_ff[l]   <= PH_W'(s8_diff[l])
                        * PH_W'(signed'({1'b0, exposure_gain_ff[GAIN_W-1:GLO_W]}));
         s9_full_ff[l] <= (FULL_W'(s8_hi_ff[l]) <<< GLO_W) + FULL_W'(s8_lo_ff[l]);
         out_ff[l]     <= out_in[l];
      end
   end

   assign rsp_strobe    = valid_ff[LATENCY-1];
   assign rsp_red_out   = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_blue_out  = out_ff[2];
   assign rsp_alpha_out = alpha_ff[LATENCY-1];

endmodule

/* hdl/pcadj_checker.sv */
// port-level timing checks for the pixel color adjust, bound to its top level
module pcadj_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [pcadj_pkg::CHAN_W-1:0]   req_alpha_in,
   input logic                           rsp_strobe,
   input logic [pcadj_pkg::CHAN_W-1:0]   rsp_alpha_out
);
   import pcadj_pkg::*;

   // every accepted pixel yields one result transfer a fixed time later
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("missing result transfer after accepted pixel");

   a_no_extra_result: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_strobe)
      else $error("result transfer without accepted pixel");

   a_alpha_kept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY (rsp_alpha_out == $past(req_alpha_in, LATENCY)))
      else $error("alpha changed through the pipeline");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_strobe)
      else $error("result transfer right after reset");

endmodule

bind pixel_color_adjust_pipeline_top pcadj_checker u_pcadj_checker (.*);

/* bench/pixel_color_adjust_pipeline_top_test.sv */
// self-checking bench for the pixel color adjust pipeline: directed table, random phases, predictor
module pixel_color_adjust_pipeline_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pcadj_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam longint UNIT = longint'(1) << FRAC;
   localparam longint HALF_UNIT = UNIT >> 1;
   localparam longint LUMA_R = ((longint'(2126) << FRAC) + 5000) / 10000;
   localparam longint LUMA_G = ((longint'(7152) << FRAC) + 5000) / 10000;
   localparam longint LUMA_B = ((longint'(722) << FRAC) + 5000) / 10000;
   localparam longint MID_HI = (longint'(1) << (MID_W - 1)) - 1;
   localparam longint MID_LO = -(longint'(1) << (MID_W - 1));
   localparam longint OUT_HI = (longint'(1) << (OUT_W - 1)) - 1;
   localparam longint OUT_LO = -(longint'(1) << (OUT_W - 1));
   localparam csr_index_type UNUSED_INDEX = csr_index_type'(3'd7);
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int PHASES = 6;
   localparam int PIXELS_PER_PHASE = 100;

   typedef struct {
      logic signed [OUT_W-1:0] red;
      logic signed [OUT_W-1:0] green;
      logic signed [OUT_W-1:0] blue;
      logic [CHAN_W-1:0]       alpha;
   } adjusted_pixel_type;

   typedef struct {
      bit                  is_write;
      csr_index_type       index;
      logic [CSR_DATA_W-1:0] data;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic [CHAN_W-1:0]   alpha;
      bit                  typed;
      adjusted_pixel_type  want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CHAN_W-1:0] req_red_in = '0;
   logic [CHAN_W-1:0] req_green_in = '0;
   logic [CHAN_W-1:0] req_blue_in = '0;
   logic [CHAN_W-1:0] req_alpha_in = '0;
   logic rsp_strobe;
   logic signed [OUT_W-1:0] rsp_red_out;
   logic signed [OUT_W-1:0] rsp_green_out;
   logic signed [OUT_W-1:0] rsp_blue_out;
   logic [CHAN_W-1:0] rsp_alpha_out;
   logic csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_SAT_SCALE;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // register copies used for prediction
   logic [SAT_W-1:0]             sat_scale_now = 14'd4096;
   logic signed [BRIGHT_W-1:0]   brightness_now = '0;
   logic [CONTRAST_W-1:0]        contrast_now = 20'd4096;
   logic signed [BLACK_W-1:0]    black_now = '0;
   logic [GAIN_W-1:0]            gain_now = 32'd4096;

   adjusted_pixel_type adjusted_pending[$];
   stim_row_type directed_rows[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int sender_gap_pct = 0;

   pixel_color_adjust_pipeline_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_alpha_in     (req_alpha_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_alpha_out    (rsp_alpha_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint round_frac(longint x);
      return (x + HALF_UNIT) >>> FRAC;
   endfunction

   function automatic longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic logic signed [OUT_W-1:0] adjust_channel(longint c, longint luma);
      longint sat_stage;
      longint contrast_stage;
      longint exposure_stage;
      sat_stage = clip(round_frac(luma * (UNIT - longint'(sat_scale_now))
                                  + c * longint'(sat_scale_now)), MID_LO, MID_HI);
      contrast_stage = round_frac((sat_stage - HALF_UNIT) * longint'(contrast_now))
                       + longint'(brightness_now) + HALF_UNIT;
      contrast_stage = clip(contrast_stage, MID_LO, MID_HI);
      exposure_stage = round_frac((contrast_stage - longint'(black_now))
                                  * longint'(gain_now));
      return OUT_W'(clip(exposure_stage, OUT_LO, OUT_HI));
   endfunction

   function automatic adjusted_pixel_type predict_adjusted(logic [CHAN_W-1:0] red,
                                                           logic [CHAN_W-1:0] green,
                                                           logic [CHAN_W-1:0] blue,
                                                           logic [CHAN_W-1:0] alpha);
      adjusted_pixel_type result;
      longint luma;
      luma = round_frac(longint'(red) * LUMA_R + longint'(green) * LUMA_G
                        + longint'(blue) * LUMA_B);
      result.red = adjust_channel(longint'(red), luma);
      result.green = adjust_channel(longint'(green), luma);
      result.blue = adjust_channel(longint'(blue), luma);
      result.alpha = alpha;
      return result;
   endfunction

   function automatic void add_pixel_row(int red, int green, int blue, int alpha);
      stim_row_type row;
      row = '{index: CSR_SAT_SCALE, default: '0};
      row.is_write = 1'b0;
      row.red = CHAN_W'(red);
      row.green = CHAN_W'(green);
      row.blue = CHAN_W'(blue);
      row.alpha = CHAN_W'(alpha);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed_row(int red, int green, int blue, int alpha,
                                         int want_red, int want_green, int want_blue);
      stim_row_type row;
      row = '{index: CSR_SAT_SCALE, default: '0};
      row.red = CHAN_W'(red);
      row.green = CHAN_W'(green);
      row.blue = CHAN_W'(blue);
      row.alpha = CHAN_W'(alpha);
      row.typed = 1'b1;
      row.want.red = OUT_W'(want_red);
      row.want.green = OUT_W'(want_green);
      row.want.blue = OUT_W'(want_blue);
      row.want.alpha = CHAN_W'(alpha);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr_row(csr_index_type index, logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{index: CSR_SAT_SCALE, default: '0};
      row.is_write = 1'b1;
      row.index = index;
      row.data = data;
      directed_rows.push_back(row);
   endfunction

   task automatic log_error(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_pixel(stim_row_type row);
      while ($urandom_range(99) < sender_gap_pct) begin
         start <= 1'b0;
         csr_write_enable <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      csr_write_enable <= 1'b0;
      req_red_in <= row.red;
      req_green_in <= row.green;
      req_blue_in <= row.blue;
      req_alpha_in <= row.alpha;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (row.typed) begin
         adjusted_pending.push_back(row.want);
      end else begin
         adjusted_pending.push_back(predict_adjusted(row.red, row.green, row.blue, row.alpha));
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      csr_write_enable <= 1'b0;
      do @(posedge clock); while (adjusted_pending.size() != 0);
   endtask

   task automatic write_csr(csr_index_type index, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      case (index)
         CSR_SAT_SCALE:        sat_scale_now = data[SAT_W-1:0];
         CSR_BRIGHTNESS_SHIFT: brightness_now = data[BRIGHT_W-1:0];
         CSR_CONTRAST_FACTOR:  contrast_now = data[CONTRAST_W-1:0];
         CSR_BLACK_LEVEL:      black_now = data[BLACK_W-1:0];
         CSR_EXPOSURE_GAIN:    gain_now = data[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_register_value(csr_index_type index);
      logic [CSR_DATA_W-1:0] value;
      logic [CSR_DATA_W-1:0] mask;
      int unsigned width;
      int unsigned roll;
      roll = $urandom_range(9);
      case (index)
         CSR_SAT_SCALE: begin
            width = SAT_W;
            case (roll)
               0: value = 0;
               1: value = 8192;
               2: value = 16383;
               3: value = $urandom;
               default: value = $urandom_range(2048, 6144);
            endcase
         end
         CSR_BRIGHTNESS_SHIFT: begin
            width = BRIGHT_W;
            case (roll)
               0: value = -4096;
               1: value = 4096;
               2: value = $urandom;
               default: value = $urandom_range(0, 1600) - 800;
            endcase
         end
         CSR_CONTRAST_FACTOR: begin
            width = CONTRAST_W;
            case (roll)
               0: value = 0;
               1: value = 1048575;
               2: value = $urandom;
               default: value = $urandom_range(1024, 12288);
            endcase
         end
         CSR_BLACK_LEVEL: begin
            width = BLACK_W;
            case (roll)
               0: value = -410;
               1: value = 410;
               2: value = $urandom;
               default: value = $urandom_range(0, 820) - 410;
            endcase
         end
         default: begin
            width = GAIN_W;
            case (roll)
               0: value = 0;
               1: value = 32'hFFFF_FFFF;
               2: value = $urandom;
               default: value = $urandom_range(2048, 8192);
            endcase
         end
      endcase
      // junk above the register width must be dropped
      if ($urandom_range(3) == 0) begin
         mask = (CSR_DATA_W'(1) << width) - 1;
         value = (value & mask) | ($urandom & ~mask);
      end
      return value;
   endfunction

   task automatic retune_registers();
      write_csr(CSR_SAT_SCALE, pick_register_value(CSR_SAT_SCALE));
      write_csr(CSR_BRIGHTNESS_SHIFT, pick_register_value(CSR_BRIGHTNESS_SHIFT));
      write_csr(CSR_CONTRAST_FACTOR, pick_register_value(CSR_CONTRAST_FACTOR));
      write_csr(CSR_BLACK_LEVEL, pick_register_value(CSR_BLACK_LEVEL));
      write_csr(CSR_EXPOSURE_GAIN, pick_register_value(CSR_EXPOSURE_GAIN));
      if ($urandom_range(3) == 0) write_csr(UNUSED_INDEX, $urandom);
   endtask

   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(9))
         0: return '0;
         1: return CHAN_W'(UNIT);
         2: return CHAN_W'($urandom);
         default: return CHAN_W'($urandom_range(0, UNIT));
      endcase
   endfunction

   function automatic stim_row_type random_pixel_row();
      stim_row_type row;
      row = '{index: CSR_SAT_SCALE, default: '0};
      row.red = random_channel();
      row.green = random_channel();
      row.blue = random_channel();
      row.alpha = random_channel();
      return row;
   endfunction

   always @(posedge clock) begin : check_results
      adjusted_pixel_type want;
      if (!reset && rsp_strobe) begin
         if (adjusted_pending.size() == 0) begin
            log_error($sformatf("result with nothing pending: %0d %0d %0d %0d",
                                rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out));
         end else begin
            want = adjusted_pending.pop_front();
            if (rsp_red_out !== want.red)
               log_error($sformatf("red got %0d want %0d", rsp_red_out, want.red));
            if (rsp_green_out !== want.green)
               log_error($sformatf("green got %0d want %0d", rsp_green_out, want.green));
            if (rsp_blue_out !== want.blue)
               log_error($sformatf("blue got %0d want %0d", rsp_blue_out, want.blue));
            if (rsp_alpha_out !== want.alpha)
               log_error($sformatf("alpha got %0d want %0d", rsp_alpha_out, want.alpha));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("pixel_color_adjust_pipeline_top regression: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase;
      // at reset defaults the pipeline is an identity on the color channels
      add_typed_row(0, 0, 0, 0, 0, 0, 0);
      add_typed_row(4096, 4096, 4096, 4096, 4096, 4096, 4096);
      add_typed_row(8191, 8191, 8191, 8191, 8191, 8191, 8191);
      add_typed_row(4096, 0, 2048, 1234, 4096, 0, 2048);
      // full desaturation, then double and beyond, then brightness and contrast extremes
      add_csr_row(CSR_SAT_SCALE, 32'd0);
      add_pixel_row(4096, 0, 0, 4096);
      add_pixel_row(0, 4096, 0, 0);
      add_csr_row(CSR_SAT_SCALE, 32'd8192);
      add_pixel_row(4096, 1000, 0, 17);
      add_csr_row(CSR_SAT_SCALE, 32'd16383);
      add_pixel_row(8191, 0, 8191, 0);
      add_csr_row(CSR_SAT_SCALE, 32'd4096);
      add_csr_row(CSR_BRIGHTNESS_SHIFT, -32'sd4096);
      add_pixel_row(0, 2048, 4096, 100);
      add_csr_row(CSR_BRIGHTNESS_SHIFT, 32'd4096);
      add_csr_row(CSR_CONTRAST_FACTOR, 32'd1048575);
      add_pixel_row(2049, 2048, 2047, 4095);
      add_csr_row(CSR_CONTRAST_FACTOR, 32'd0);
      add_pixel_row(4096, 123, 0, 1);
      // saturate both ways through the exposure stage
      add_csr_row(CSR_CONTRAST_FACTOR, 32'd4096);
      add_csr_row(CSR_BRIGHTNESS_SHIFT, 32'd0);
      add_csr_row(CSR_EXPOSURE_GAIN, 32'hFFFF_FFFF);
      add_csr_row(CSR_BLACK_LEVEL, 32'd410);
      add_typed_row(0, 0, 0, 0, -32768, -32768, -32768);
      add_typed_row(4096, 4096, 4096, 4096, 32767, 32767, 32767);
      add_csr_row(CSR_BLACK_LEVEL, -32'sd410);
      add_csr_row(CSR_EXPOSURE_GAIN, 32'd0);
      add_typed_row(4096, 2048, 0, 777, 0, 0, 0);
      // writes to an index past the register list change nothing
      add_csr_row(CSR_EXPOSURE_GAIN, 32'd4096);
      add_csr_row(CSR_BLACK_LEVEL, 32'd0);
      add_csr_row(UNUSED_INDEX, 32'h0000_0155);
      add_typed_row(1234, 2345, 3456, 4000, 1234, 2345, 3456);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            if (i == 0 || !directed_rows[i-1].is_write) drain_results();
            write_csr(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_pixel(directed_rows[i]);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         retune_registers();
         case (phase % 3)
            0: sender_gap_pct = 0;
            1: sender_gap_pct = 60;
            default: sender_gap_pct = 18;
         endcase
         repeat (PIXELS_PER_PHASE) send_pixel(random_pixel_row());
      end

      start <= 1'b0;
      csr_write_enable <= 1'b0;
      while (adjusted_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (adjusted_pending.size() != 0)
         log_error($sformatf("%0d results never arrived", adjusted_pending.size()));
      if (mismatch_count == 0) begin
         $display("pixel_color_adjust_pipeline_top regression: pass");
      end else begin
         $display("pixel_color_adjust_pipeline_top regression: fail");
      end
      $finish;
   end

endmodule
